@@ hw/rtl/stsi_pkg.sv @@
// Shared types and constants for the sorted table search and insert block.
// Used by stsi_cmp, stsi_ram and sorted_table_search_insert; depends on nothing.
`timescale 1ns / 1ps

package stsi_pkg;

    // Width of one table entry and of the reported index and count fields.
    localparam int DATA_W = 32;
    localparam int POS_W  = 9;

    typedef logic signed [DATA_W-1:0] t_data;

    // Transaction kinds carried on the mode input.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Result of the shared signed comparator.
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp_res;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_CHK,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_PUT,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR
    } t_state;

endpackage

@@ hw/rtl/sorted_table_search_insert.sv @@
// Top level: sequencer and datapath of the sorted table with search and insertion.
// Depends on stsi_pkg, stsi_cmp and stsi_ram.
//
//  Channel   Ports                                              Handshake
//  --------  -------------------------------------------------  -----------------------------
//  command   i_mode, i_value                                    taken when start && !busy
//  result    o_found, o_position, o_entry_count, o_table_full   one-cycle strobe on o_valid
//
// A load is handled while idle; its result strobes on the cycle after it is taken.
// A query first insertion-sorts any entries loaded since the last query: each key is
// checked, fetched, then compared and moved down a place at a time until written into
// its place, and a last check moves on to the search. Binary search takes a check and a
// compare state per probe; an insertion moves each entry from the insertion point up one
// place through the store's one read and one write port, then writes the value. busy is high
// from the cycle after a query is taken to the cycle before its result strobes. Reset
// empties the table at once; no clearing pass is needed. Results cannot be stalled.
`timescale 1ns / 1ps

module sorted_table_search_insert #(
    parameter int DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_mode,
    input  logic signed [stsi_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    output logic                               o_found,
    output logic        [stsi_pkg::POS_W-1:0]  o_position,
    output logic        [stsi_pkg::POS_W-1:0]  o_entry_count,
    output logic                               o_table_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > stsi_pkg::POS_W) ? CW : stsi_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Output fields are the low bits of the internal counters.
    function automatic logic [stsi_pkg::POS_W-1:0] to_out(input logic [CW-1:0] x);
        logic [OW-1:0] t;
        t = OW'(x);
        return t[stsi_pkg::POS_W-1:0];
    endfunction

    stsi_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_sorted, n_sorted;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_pos, n_pos;
    stsi_pkg::t_data r_key, n_key;
    stsi_pkg::t_data r_val, n_val;
    logic r_done, n_done;
    logic r_found, n_found;
    logic r_full, n_full;
    logic [stsi_pkg::POS_W-1:0] r_position, n_position;
    logic [stsi_pkg::POS_W-1:0] r_entry_count, n_entry_count;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    stsi_pkg::t_data mem_wdata;
    logic [AW-1:0]   mem_raddr;
    stsi_pkg::t_data rd_data;
    stsi_pkg::t_cmp_res cmp;

    logic [CW-1:0] j_m1, j_m2, span, mid;

    stsi_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // The stored entry is always compared against the key register.
    stsi_cmp u_cmp (
        .i_a   (rd_data),
        .i_b   (r_key),
        .o_res (cmp)
    );

    // Index arithmetic shared by the phases.
    always_comb begin
        j_m1 = r_j - CW'(1);
        j_m2 = r_j - CW'(2);
        span = r_hi - r_lo - CW'(1);
        mid  = r_lo + (span >> 1);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stsi_pkg::S_IDLE;
            r_count  <= '0;
            r_sorted <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sorted <= n_sorted;
            r_done   <= n_done;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_i           <= n_i;
        r_j           <= n_j;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_pos         <= n_pos;
        r_key         <= n_key;
        r_val         <= n_val;
        r_found       <= n_found;
        r_full        <= n_full;
        r_position    <= n_position;
        r_entry_count <= n_entry_count;
    end

    // Sequencer: store a load, or sort the unsorted tail, binary search, then shift and insert on a miss.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_sorted      = r_sorted;
        n_i           = r_i;
        n_j           = r_j;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_pos         = r_pos;
        n_key         = r_key;
        n_val         = r_val;
        n_done        = 1'b0;
        n_found       = r_found;
        n_full        = r_full;
        n_position    = r_position;
        n_entry_count = r_entry_count;
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_j);
        mem_wdata     = r_key;
        mem_raddr     = '0;

        unique case (r_state)
            stsi_pkg::S_IDLE: begin
                if (start) begin
                    n_val = i_value;
                    if (i_mode == stsi_pkg::MODE_LOAD) begin
                        n_found    = 1'b0;
                        n_position = to_out(r_count);
                        if (r_count < DEPTH_C) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(r_count);
                            mem_wdata = i_value;
                            n_count   = r_count + CW'(1);
                            n_full    = 1'b0;
                        end else begin
                            n_full = 1'b1;
                        end
                        n_entry_count = to_out(n_count);
                        n_done        = 1'b1;
                    end else begin
                        n_i     = (r_sorted == '0) ? CW'(1) : r_sorted;
                        n_state = stsi_pkg::S_SORT_CHK;
                    end
                end
            end

            // Pick the next unsorted key, or move on to the search.
            stsi_pkg::S_SORT_CHK: begin
                if (r_i >= r_count) begin
                    n_sorted = r_count;
                    n_key    = r_val;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_state  = stsi_pkg::S_SRCH_CHK;
                end else begin
                    mem_raddr = AW'(r_i);
                    n_state   = stsi_pkg::S_SORT_KEY;
                end
            end

            stsi_pkg::S_SORT_KEY: begin
                n_key     = rd_data;
                n_j       = r_i;
                mem_raddr = AW'(r_i - CW'(1));
                n_state   = stsi_pkg::S_SORT_CMP;
            end

            // Move larger entries up one place while fetching the next one down, or write the key into its place.
            stsi_pkg::S_SORT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_j);
                if (cmp.gt) begin
                    mem_wdata = rd_data;
                    n_j       = j_m1;
                    if (j_m1 == '0) begin
                        n_state = stsi_pkg::S_SORT_PUT;
                    end else begin
                        mem_raddr = AW'(j_m2);
                    end
                end else begin
                    mem_wdata = r_key;
                    n_i       = r_i + CW'(1);
                    n_state   = stsi_pkg::S_SORT_CHK;
                end
            end

            stsi_pkg::S_SORT_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_j);
                mem_wdata = r_key;
                n_i       = r_i + CW'(1);
                n_state   = stsi_pkg::S_SORT_CHK;
            end

            // Probe the middle of the open range, or settle a miss.
            stsi_pkg::S_SRCH_CHK: begin
                if (r_lo < r_hi) begin
                    n_mid     = mid;
                    mem_raddr = AW'(mid);
                    n_state   = stsi_pkg::S_SRCH_CMP;
                end else begin
                    n_found    = 1'b0;
                    n_position = to_out(r_lo);
                    n_pos      = r_lo;
                    if (r_count < DEPTH_C) begin
                        n_j     = r_count;
                        n_state = stsi_pkg::S_SHIFT_CHK;
                    end else begin
                        n_full        = 1'b1;
                        n_entry_count = to_out(r_count);
                        n_done        = 1'b1;
                        n_state       = stsi_pkg::S_IDLE;
                    end
                end
            end

            stsi_pkg::S_SRCH_CMP: begin
                priority if (cmp.eq) begin
                    n_found       = 1'b1;
                    n_full        = 1'b0;
                    n_position    = to_out(r_mid);
                    n_entry_count = to_out(r_count);
                    n_done        = 1'b1;
                    n_state       = stsi_pkg::S_IDLE;
                end else if (cmp.lt) begin
                    n_lo    = r_mid + CW'(1);
                    n_state = stsi_pkg::S_SRCH_CHK;
                end else begin
                    n_hi    = r_mid;
                    n_state = stsi_pkg::S_SRCH_CHK;
                end
            end

            // Open a gap at the insertion point, or write the new value into it.
            stsi_pkg::S_SHIFT_CHK: begin
                if (r_j > r_pos) begin
                    mem_raddr = AW'(j_m1);
                    n_state   = stsi_pkg::S_SHIFT_WR;
                end else begin
                    mem_we        = 1'b1;
                    mem_waddr     = AW'(r_pos);
                    mem_wdata     = r_val;
                    n_count       = r_count + CW'(1);
                    n_sorted      = r_count + CW'(1);
                    n_full        = 1'b0;
                    n_entry_count = to_out(r_count + CW'(1));
                    n_done        = 1'b1;
                    n_state       = stsi_pkg::S_IDLE;
                end
            end

            stsi_pkg::S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_j);
                mem_wdata = rd_data;
                n_j       = j_m1;
                if (j_m1 > r_pos) begin
                    mem_raddr = AW'(j_m2);
                end else begin
                    n_state = stsi_pkg::S_SHIFT_CHK;
                end
            end

            default: begin
                n_state = stsi_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != stsi_pkg::S_IDLE);
    assign o_valid       = r_done;
    assign o_found       = r_found;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;
    assign o_table_full  = r_full;

    // The count never passes the table depth, and the sorted prefix never passes the count.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_C) && (r_sorted <= r_count))
        else $error("entry count or sorted prefix out of range");

    // The search range never inverts.
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stsi_pkg::S_SRCH_CHK) |-> (r_lo <= r_hi))
        else $error("search range inverted");

    // A taken transaction either strobes its result next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction made no progress");

    // A result strobe follows busy work or a taken load.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result strobe without a transaction");

    // Shifting only happens while there is room for the new entry.
    a_shift_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stsi_pkg::S_SHIFT_WR) |-> (r_count < DEPTH_C) && (r_j > r_pos))
        else $error("shift outside the table");

endmodule

@@ hw/rtl/stsi_cmp.sv @@
// Shared signed 32-bit comparator used by the sort and search phases.
// Depends on stsi_pkg for the data and result types.
`timescale 1ns / 1ps

module stsi_cmp (
    input  stsi_pkg::t_data    i_a,
    input  stsi_pkg::t_data    i_b,
    output stsi_pkg::t_cmp_res o_res
);

    // Three signed compares give the three relations.
    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
        o_res.gt = (i_a > i_b);
    end

endmodule

@@ hw/rtl/stsi_ram.sv @@
// Entry store: one write port and one read port with registered read data.
// Depends on stsi_pkg for the entry type.
`timescale 1ns / 1ps

module stsi_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  stsi_pkg::t_data          i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output stsi_pkg::t_data          o_rdata
);

    stsi_pkg::t_data r_mem [DEPTH];
    stsi_pkg::t_data r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data appears the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
